>>> rtl/rdte_pkg.sv
// Shared widths, constants, types and helper functions for the RTC date to epoch core.
package rdte_pkg;

    localparam int ByteW   = 8;
    localparam int YearW   = 17;
    localparam int SYearW  = 18;
    localparam int TodW    = 20;
    localparam int DaysW   = 28;
    localparam int SecW    = 48;
    localparam int EpochW  = 64;
    localparam int ZoneW   = 17;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 17;
    localparam int QuotW   = 11;

    localparam logic [CfgIdxW-1:0] CfgBcdFormat   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgUtcOnly     = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgDstInEffect = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgZoneOffset  = 2'd3;

    // x / 100 = (x * Recip100) >> Recip100Shift, exact for x below 199728
    localparam int Recip100      = 167773;
    localparam int Recip100W     = 18;
    localparam int Recip100Shift = 24;
    // m / 12 = (m * Recip12) >> Recip12Shift, exact for m below 512
    localparam int Recip12      = 171;
    localparam int Recip12Shift = 11;

    localparam int EpochYear   = 1970;
    localparam int LeapBase4   = 1968;
    localparam int LeapBase100 = 1900;
    localparam int LeapBase400 = 1600;
    localparam int DaysPerYear = 365;
    localparam int SecPerDay   = 86400;
    localparam int SecPerHour  = 3600;
    localparam int SecPerMin   = 60;

    typedef struct packed {
        logic                    bcd_format;
        logic                    utc_only;
        logic                    dst_in_effect;
        logic signed [ZoneW-1:0] zone_offset;
    } t_cfg;

    function automatic logic [ByteW-1:0] from_bcd(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] tens;
        tens = {4'b0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'b0, b[3:0]};
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/rdte_decode.sv
// Byte decode and month normalization stages: yields year offsets, day of year part and time of day.
module rdte_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_bcd_format,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rdte_pkg::ByteW-1:0]  i_year_first,
    input  logic [rdte_pkg::ByteW-1:0]  i_year_second,
    input  logic [rdte_pkg::ByteW-1:0]  i_month_raw,
    input  logic [rdte_pkg::ByteW-1:0]  i_day_raw,
    input  logic [rdte_pkg::ByteW-1:0]  i_hour_raw,
    input  logic [rdte_pkg::ByteW-1:0]  i_minute_raw,
    input  logic [rdte_pkg::ByteW-1:0]  i_second_raw,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rdte_pkg::SYearW-1:0] o_year_off,
    output logic [rdte_pkg::SYearW-1:0] o_a4,
    output logic [rdte_pkg::SYearW-1:0] o_a100,
    output logic [rdte_pkg::SYearW-1:0] o_a400,
    output logic [8:0]                  o_dbm,
    output logic [rdte_pkg::ByteW-1:0]  o_day,
    output logic [rdte_pkg::TodW-1:0]   o_tod
);
    import rdte_pkg::*;

    logic               r1_valid;
    logic [YearW-1:0]   r1_year;
    logic [ByteW-1:0]   r1_month;
    logic [ByteW-1:0]   r1_day;
    logic [ByteW-1:0]   r1_hour;
    logic [ByteW-1:0]   r1_min;
    logic [ByteW-1:0]   r1_sec;
    logic               r2_valid;
    logic [SYearW-1:0]  r2_year_off;
    logic [SYearW-1:0]  r2_a4;
    logic [SYearW-1:0]  r2_a100;
    logic [SYearW-1:0]  r2_a400;
    logic [8:0]         r2_dbm;
    logic [ByteW-1:0]   r2_day;
    logic [TodW-1:0]    r2_tod;

    logic               ready1;
    logic               ready2;
    logic [ByteW-1:0]   f0, f1, f2, f3, f4, f5, f6;
    logic [YearW-1:0]   n1_year;
    logic [15:0]        qprod;
    logic [4:0]         q12;
    logic [3:0]         rem12;
    logic [SYearW-1:0]  year2;
    logic [SYearW-1:0]  yadj;
    logic [TodW-1:0]    n2_tod;

    assign ready2  = !r2_valid || i_ready;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;

    always_comb begin
        f0 = i_bcd_format ? from_bcd(i_year_first)  : i_year_first;
        f1 = i_bcd_format ? from_bcd(i_year_second) : i_year_second;
        f2 = i_bcd_format ? from_bcd(i_month_raw)   : i_month_raw;
        f3 = i_bcd_format ? from_bcd(i_day_raw)     : i_day_raw;
        f4 = i_bcd_format ? from_bcd(i_hour_raw)    : i_hour_raw;
        f5 = i_bcd_format ? from_bcd(i_minute_raw)  : i_minute_raw;
        f6 = i_bcd_format ? from_bcd(i_second_raw)  : i_second_raw;
        if (i_bcd_format) begin
            n1_year = YearW'(f0) * YearW'(100) + YearW'(f1);
        end else begin
            n1_year = {1'b0, f1, f0};
        end
    end

    always_comb begin
        qprod  = 16'(r1_month) * 16'(Recip12);
        q12    = qprod[15:Recip12Shift];
        rem12  = 4'(r1_month - ByteW'(q12) * ByteW'(12));
        year2  = {1'b0, r1_year} + SYearW'(q12);
        yadj   = (rem12 <= 4'd1) ? year2 - SYearW'(1) : year2;
        n2_tod = TodW'(r1_hour) * TodW'(SecPerHour) + TodW'(r1_min) * TodW'(SecPerMin)
               + TodW'(r1_sec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (ready1) r1_valid <= i_valid;
            if (ready2) r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r1_year  <= n1_year;
            r1_month <= f2;
            r1_day   <= f3;
            r1_hour  <= f4;
            r1_min   <= f5;
            r1_sec   <= f6;
        end
        if (ready2 && r1_valid) begin
            r2_year_off <= year2 - SYearW'(EpochYear);
            r2_a4       <= yadj - SYearW'(LeapBase4);
            r2_a100     <= yadj - SYearW'(LeapBase100);
            r2_a400     <= yadj - SYearW'(LeapBase400);
            r2_dbm      <= days_before_month(rem12);
            r2_day      <= r1_day;
            r2_tod      <= n2_tod;
        end
    end

    assign o_valid    = r2_valid;
    assign o_year_off = r2_year_off;
    assign o_a4       = r2_a4;
    assign o_a100     = r2_a100;
    assign o_a400     = r2_a400;
    assign o_dbm      = r2_dbm;
    assign o_day      = r2_day;
    assign o_tod      = r2_tod;

endmodule

>>> rtl/rdte_days.sv
// Day count stages: year days, truncating leap corrections by reciprocal multiply, final sum.
module rdte_days (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rdte_pkg::SYearW-1:0] i_year_off,
    input  logic [rdte_pkg::SYearW-1:0] i_a4,
    input  logic [rdte_pkg::SYearW-1:0] i_a100,
    input  logic [rdte_pkg::SYearW-1:0] i_a400,
    input  logic [8:0]                  i_dbm,
    input  logic [rdte_pkg::ByteW-1:0]  i_day,
    input  logic [rdte_pkg::TodW-1:0]   i_tod,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rdte_pkg::DaysW-1:0]  o_days,
    output logic [rdte_pkg::TodW-1:0]   o_tod
);
    import rdte_pkg::*;

    localparam int ProdW = YearW + Recip100W;

    logic                r3_valid;
    logic [DaysW-1:0]    r3_days;
    logic [SYearW-1:0]   r3_d4;
    logic                r3_s100;
    logic                r3_s400;
    logic [YearW-1:0]    r3_m100;
    logic [YearW-1:0]    r3_m400;
    logic [TodW-1:0]     r3_tod;
    logic                r4_valid;
    logic [DaysW-1:0]    r4_days;
    logic [SYearW-1:0]   r4_d4;
    logic                r4_s100;
    logic                r4_s400;
    logic [QuotW-1:0]    r4_q100;
    logic [QuotW-1:0]    r4_q400;
    logic [TodW-1:0]     r4_tod;
    logic                r5_valid;
    logic [DaysW-1:0]    r5_days;
    logic [TodW-1:0]     r5_tod;

    logic                ready3, ready4, ready5;
    logic [DaysW-1:0]    n3_days;
    logic [SYearW-1:0]   mag4, mag100, mag400, sh4, n3_d4;
    logic [ProdW-1:0]    p100, p400;
    logic [DaysW-1:0]    t4, t100, t400;

    assign ready5  = !r5_valid || i_ready;
    assign ready4  = !r4_valid || ready5;
    assign ready3  = !r3_valid || ready4;
    assign o_ready = ready3;

    always_comb begin
        n3_days = DaysW'($signed(i_year_off)) * DaysW'(DaysPerYear) + DaysW'(i_dbm)
                + DaysW'(i_day) - DaysW'(1);
        mag4    = i_a4[SYearW-1]   ? SYearW'(0) - i_a4   : i_a4;
        mag100  = i_a100[SYearW-1] ? SYearW'(0) - i_a100 : i_a100;
        mag400  = i_a400[SYearW-1] ? SYearW'(0) - i_a400 : i_a400;
        sh4     = mag4 >> 2;
        n3_d4   = i_a4[SYearW-1] ? SYearW'(0) - sh4 : sh4;
    end

    always_comb begin
        p100 = ProdW'(r3_m100) * ProdW'(Recip100);
        p400 = ProdW'(r3_m400 >> 2) * ProdW'(Recip100);
    end

    always_comb begin
        t4   = DaysW'($signed(r4_d4));
        t100 = r4_s100 ? DaysW'(0) - DaysW'(r4_q100) : DaysW'(r4_q100);
        t400 = r4_s400 ? DaysW'(0) - DaysW'(r4_q400) : DaysW'(r4_q400);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (ready3) r3_valid <= i_valid;
            if (ready4) r4_valid <= r3_valid;
            if (ready5) r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && i_valid) begin
            r3_days <= n3_days;
            r3_d4   <= n3_d4;
            r3_s100 <= i_a100[SYearW-1];
            r3_s400 <= i_a400[SYearW-1];
            r3_m100 <= mag100[YearW-1:0];
            r3_m400 <= mag400[YearW-1:0];
            r3_tod  <= i_tod;
        end
        if (ready4 && r3_valid) begin
            r4_days <= r3_days;
            r4_d4   <= r3_d4;
            r4_s100 <= r3_s100;
            r4_s400 <= r3_s400;
            r4_q100 <= p100[Recip100Shift +: QuotW];
            r4_q400 <= p400[Recip100Shift +: QuotW];
            r4_tod  <= r3_tod;
        end
        if (ready5 && r4_valid) begin
            r5_days <= r4_days + t4 - t100 + t400;
            r5_tod  <= r4_tod;
        end
    end

    assign o_valid = r5_valid;
    assign o_days  = r5_days;
    assign o_tod   = r5_tod;

endmodule

>>> rtl/rdte_secs.sv
// Seconds stages: days times seconds per day, then time of day, zone offset and DST correction.
module rdte_secs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdte_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rdte_pkg::DaysW-1:0]  i_days,
    input  logic [rdte_pkg::TodW-1:0]   i_tod,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rdte_pkg::EpochW-1:0] o_epoch_seconds
);
    import rdte_pkg::*;

    logic              r6_valid;
    logic [SecW-1:0]   r6_prod;
    logic [TodW-1:0]   r6_tod;
    logic              r7_valid;
    logic [EpochW-1:0] r7_secs;

    logic              ready6, ready7;
    logic [SecW-1:0]   n6_prod;
    logic [SecW-1:0]   n7_secs;
    logic [SecW-1:0]   dst_adj;

    assign ready7  = !r7_valid || i_ready;
    assign ready6  = !r6_valid || ready7;
    assign o_ready = ready6;

    always_comb begin
        n6_prod = SecW'($signed(i_days)) * SecW'(SecPerDay);
        dst_adj = (i_cfg.dst_in_effect && !i_cfg.utc_only) ? SecW'(SecPerHour) : SecW'(0);
        n7_secs = r6_prod + SecW'(r6_tod) + SecW'(i_cfg.zone_offset) - dst_adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            if (ready6) r6_valid <= i_valid;
            if (ready7) r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready6 && i_valid) begin
            r6_prod <= n6_prod;
            r6_tod  <= i_tod;
        end
        if (ready7 && r6_valid) begin
            r7_secs <= EpochW'($signed(n7_secs));
        end
    end

    assign o_valid         = r7_valid;
    assign o_epoch_seconds = r7_secs;

endmodule

>>> rtl/rtc_date_to_epoch_seconds_core.sv
// RTC date bytes to signed epoch seconds: 7-stage pipeline with configuration registers.
// Throughput: one transaction per cycle; each stage holds while its successor is full and stalled.
// The days by 86400 multiply and the reciprocal divides by 100 and 400 set the stage split.
// Reset (synchronous, active low) empties the pipeline and sets BCD format and UTC only,
// DST clear and zone offset zero. Configuration writes are accepted every cycle.
module rtc_date_to_epoch_seconds_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rdte_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [rdte_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rdte_pkg::ByteW-1:0]    i_year_first,
    input  logic [rdte_pkg::ByteW-1:0]    i_year_second,
    input  logic [rdte_pkg::ByteW-1:0]    i_month_raw,
    input  logic [rdte_pkg::ByteW-1:0]    i_day_raw,
    input  logic [rdte_pkg::ByteW-1:0]    i_hour_raw,
    input  logic [rdte_pkg::ByteW-1:0]    i_minute_raw,
    input  logic [rdte_pkg::ByteW-1:0]    i_second_raw,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rdte_pkg::EpochW-1:0]   o_epoch_seconds
);
    import rdte_pkg::*;

    t_cfg              r_cfg;

    logic              dec_valid, dec_ready;
    logic [SYearW-1:0] dec_year_off, dec_a4, dec_a100, dec_a400;
    logic [8:0]        dec_dbm;
    logic [ByteW-1:0]  dec_day;
    logic [TodW-1:0]   dec_tod;
    logic              days_valid, days_ready;
    logic [DaysW-1:0]  days_days;
    logic [TodW-1:0]   days_tod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bcd_format    <= 1'b1;
            r_cfg.utc_only      <= 1'b1;
            r_cfg.dst_in_effect <= 1'b0;
            r_cfg.zone_offset   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgBcdFormat:   r_cfg.bcd_format    <= i_cfg_data[0];
                CfgUtcOnly:     r_cfg.utc_only      <= i_cfg_data[0];
                CfgDstInEffect: r_cfg.dst_in_effect <= i_cfg_data[0];
                CfgZoneOffset:  r_cfg.zone_offset   <= $signed(i_cfg_data[ZoneW-1:0]);
                default: ;
            endcase
        end
    end

    rdte_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bcd_format  (r_cfg.bcd_format),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_year_first  (i_year_first),
        .i_year_second (i_year_second),
        .i_month_raw   (i_month_raw),
        .i_day_raw     (i_day_raw),
        .i_hour_raw    (i_hour_raw),
        .i_minute_raw  (i_minute_raw),
        .i_second_raw  (i_second_raw),
        .o_valid       (dec_valid),
        .i_ready       (dec_ready),
        .o_year_off    (dec_year_off),
        .o_a4          (dec_a4),
        .o_a100        (dec_a100),
        .o_a400        (dec_a400),
        .o_dbm         (dec_dbm),
        .o_day         (dec_day),
        .o_tod         (dec_tod)
    );

    rdte_days u_days (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (dec_valid),
        .o_ready    (dec_ready),
        .i_year_off (dec_year_off),
        .i_a4       (dec_a4),
        .i_a100     (dec_a100),
        .i_a400     (dec_a400),
        .i_dbm      (dec_dbm),
        .i_day      (dec_day),
        .i_tod      (dec_tod),
        .o_valid    (days_valid),
        .i_ready    (days_ready),
        .o_days     (days_days),
        .o_tod      (days_tod)
    );

    rdte_secs u_secs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (days_valid),
        .o_ready         (days_ready),
        .i_days          (days_days),
        .i_tod           (days_tod),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule
